// File: rtl/amgs_pkg.sv
package amgs_pkg;

  localparam int FIELD_W = 7;
  localparam int REQ_W   = 2;
  localparam logic [FIELD_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_EDGE = 2'd0,
    REQ_SUCC     = 2'd1,
    REQ_PRED     = 2'd2,
    REQ_COUNT    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    EMIT_NONE     = 2'd0,
    EMIT_REJECT   = 2'd1,
    EMIT_EMPTY    = 2'd2,
    EMIT_NEIGHBOR = 2'd3
  } emit_t;

  typedef struct packed {
    logic  capture;
    logic  rd_row_src;
    logic  rd_row_ctr;
    logic  add_commit;
    logic  load_row;
    logic  clr_vec;
    logic  ctr_clr;
    logic  ctr_inc;
    logic  scan_step;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic src_ok;
    logic dst_ok;
    logic ctr_end;
    logic vec_empty;
    logic scan_last;
  } dp_stat_t;

endpackage

// File: rtl/amgs_dp.sv
module amgs_dp #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  amgs_pkg::dp_cmd_t         cmd,
  output amgs_pkg::dp_stat_t        st,
  input  logic                      busy,
  input  logic [1:0]                req_type,
  input  logic [6:0]                src_vertex,
  input  logic [6:0]                dst_vertex,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [6:0]                cfg_data,
  output logic                      result_valid,
  output logic [6:0]                neighbor,
  output logic                      found,
  output logic                      accepted,
  output logic [6:0]                vertices_used,
  output logic                      last
);
  import amgs_pkg::*;

  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

  logic [FIELD_W-1:0]      dim;
  logic [CNT_W-1:0]        dim_eff;
  logic [CMP_W-1:0]        dim_cmp;
  req_t                    req_q;
  logic [FIELD_W-1:0]      src_q;
  logic [FIELD_W-1:0]      dst_q;
  logic [IDX_W-1:0]        src_idx;
  logic [IDX_W-1:0]        dst_idx;
  logic [IDX_W-1:0]        ctr;
  logic [IDX_W-1:0]        rd_addr;
  logic                    rd_en;
  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] rdata;
  logic                    rd_valid;
  logic [MAX_VERTICES-1:0] row_data;
  logic [MAX_VERTICES-1:0] row_new;
  logic [MAX_VERTICES-1:0] dim_mask;
  logic [MAX_VERTICES-1:0] vec;
  logic [MAX_VERTICES-1:0] ctr_onehot;
  logic [MAX_VERTICES-1:0] vec_rest;
  logic                    col_pend;
  logic [IDX_W-1:0]        col_idx;
  logic [MAX_VERTICES-1:0] present;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    new_src;
  logic                    new_dst;
  logic                    cur_bit;
  logic [CMP_W-1:0]        nb_sum;
  logic [CMP_W-1:0]        cnt_ext;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dim <= cfg_data;
    end
  end

  // dimension saturates at the matrix size
  always_comb begin
    if (CMP_W'(dim) > CMP_W'(MAX_VERTICES)) begin
      dim_eff = CNT_W'(MAX_VERTICES);
    end else begin
      dim_eff = CNT_W'(dim);
    end
  end
  assign dim_cmp = CMP_W'(dim_eff);

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      dim_mask[j] = CMP_W'(j) < dim_cmp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_t'(req_type);
      src_q <= src_vertex;
      dst_q <= dst_vertex;
    end
  end

  assign src_idx = IDX_W'(CMP_W'(src_q) - CMP_W'(1));
  assign dst_idx = IDX_W'(CMP_W'(dst_q) - CMP_W'(1));

  assign st.req       = req_q;
  assign st.src_ok    = (src_q != '0) && (CMP_W'(src_q) <= dim_cmp);
  assign st.dst_ok    = (dst_q != '0) && (CMP_W'(dst_q) <= dim_cmp);
  assign st.ctr_end   = (CMP_W'(ctr) + CMP_W'(1)) == dim_cmp;
  assign st.vec_empty = (vec == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
    end else if (cmd.ctr_clr) begin
      ctr <= '0;
    end else if (cmd.ctr_inc) begin
      ctr <= ctr + IDX_W'(1);
    end
  end

  // row memory, one row read or written per cycle
  assign rd_en   = cmd.rd_row_src || cmd.rd_row_ctr;
  assign rd_addr = cmd.rd_row_src ? src_idx : ctr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.add_commit) begin
      mem[src_idx] <= row_new;
    end
  end

  // rows never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
      col_pend  <= 1'b0;
      col_idx   <= '0;
    end else begin
      if (rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
      if (cmd.add_commit) begin
        row_valid[src_idx] <= 1'b1;
      end
      col_pend <= cmd.rd_row_ctr;
      col_idx  <= ctr;
    end
  end

  assign row_data = rd_valid ? rdata : '0;
  assign row_new  = row_data | (MAX_VERTICES'(1) << dst_idx);

  assign new_src = !present[src_idx];
  assign new_dst = !present[dst_idx] && (dst_idx != src_idx);

  always_comb begin
    count_next = count;
    if (cmd.add_commit) begin
      count_next = count + CNT_W'(new_src) + CNT_W'(new_dst);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      count   <= '0;
    end else begin
      if (cmd.add_commit) begin
        present <= present | (MAX_VERTICES'(1) << src_idx) |
                   (MAX_VERTICES'(1) << dst_idx);
      end
      count <= count_next;
    end
  end

  // neighbor vector: a row for successors, a gathered column for predecessors
  assign ctr_onehot   = MAX_VERTICES'(1) << ctr;
  assign cur_bit      = vec[ctr];
  assign vec_rest     = vec & ~ctr_onehot;
  assign st.scan_last = cur_bit && (vec_rest == '0);

  always_ff @(posedge clk) begin
    if (cmd.clr_vec) begin
      vec <= '0;
    end else if (cmd.load_row) begin
      vec <= row_data & dim_mask;
    end else if (col_pend) begin
      vec[col_idx] <= row_data[src_idx];
    end else if (cmd.scan_step) begin
      vec <= vec_rest;
    end
  end

  assign nb_sum  = CMP_W'(ctr) + CMP_W'(1);
  assign cnt_ext = CMP_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit == EMIT_REJECT) || (cmd.emit == EMIT_EMPTY) ||
                      ((cmd.emit == EMIT_NEIGHBOR) && cur_bit);
    end
  end

  always_ff @(posedge clk) begin
    vertices_used <= cnt_ext[FIELD_W-1:0];
    case (cmd.emit)
      EMIT_NEIGHBOR: begin
        neighbor <= nb_sum[FIELD_W-1:0];
        found    <= 1'b1;
        accepted <= 1'b1;
        last     <= st.scan_last;
      end
      EMIT_REJECT: begin
        neighbor <= '0;
        found    <= 1'b0;
        accepted <= 1'b0;
        last     <= 1'b1;
      end
      default: begin
        neighbor <= '0;
        found    <= 1'b0;
        accepted <= 1'b1;
        last     <= 1'b1;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(MAX_VERTICES))
    else $error("present count above vertex limit");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> neighbor == '0 && last)
    else $error("empty result carries a neighbor or is not last");

  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && !accepted |-> !found)
    else $error("rejected request reports a neighbor");

endmodule

// File: rtl/amgs_ctrl.sv
module amgs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output amgs_pkg::dp_cmd_t   cmd,
  input  amgs_pkg::dp_stat_t  st
);
  import amgs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_WAIT,
    S_ROW_WAIT,
    S_COL_RD,
    S_COL_LAST,
    S_CHECK,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.req)
          REQ_ADD_EDGE: begin
            if (st.src_ok && st.dst_ok) begin
              cmd.rd_row_src = 1'b1;
              state_next     = S_ADD_WAIT;
            end else begin
              cmd.emit   = EMIT_REJECT;
              state_next = S_IDLE;
            end
          end
          REQ_SUCC: begin
            if (st.src_ok) begin
              cmd.rd_row_src = 1'b1;
              state_next     = S_ROW_WAIT;
            end else begin
              cmd.emit   = EMIT_REJECT;
              state_next = S_IDLE;
            end
          end
          REQ_PRED: begin
            if (st.src_ok) begin
              cmd.clr_vec = 1'b1;
              cmd.ctr_clr = 1'b1;
              state_next  = S_COL_RD;
            end else begin
              cmd.emit   = EMIT_REJECT;
              state_next = S_IDLE;
            end
          end
          default: begin
            cmd.emit   = EMIT_EMPTY;
            state_next = S_IDLE;
          end
        endcase
      end
      S_ADD_WAIT: begin
        cmd.add_commit = 1'b1;
        cmd.emit       = EMIT_EMPTY;
        state_next     = S_IDLE;
      end
      S_ROW_WAIT: begin
        cmd.load_row = 1'b1;
        cmd.ctr_clr  = 1'b1;
        state_next   = S_CHECK;
      end
      S_COL_RD: begin
        cmd.rd_row_ctr = 1'b1;
        if (st.ctr_end) begin
          state_next = S_COL_LAST;
        end else begin
          cmd.ctr_inc = 1'b1;
        end
      end
      S_COL_LAST: begin
        // last column bit lands in the vector this cycle
        cmd.ctr_clr = 1'b1;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        if (st.vec_empty) begin
          cmd.emit   = EMIT_EMPTY;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.ctr_inc   = 1'b1;
        cmd.emit      = EMIT_NEIGHBOR;
        if (st.scan_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE))
    else $error("busy out of step with controller state");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but controller not busy");

endmodule

// File: rtl/adjacency_matrix_graph_store.sv
// Directed graph store on a bit adjacency matrix, vertices numbered from 1.
// A request is taken when start is high and busy is low; results come out one
// per cycle on result_valid and cannot be held off, so the receiver must take
// each one in the cycle it appears. An add edge request gives its one result
// after a row read and a commit; count and rejected requests give theirs
// straight from the decode state. A successor query reads the vertex's row in
// one memory access, then checks one bit per cycle.
// A predecessor query first gathers the column by reading every row 1..dim
// through the single row memory port, then scans it.
// Reset clears the row valid bits, presence map and count, with no clearing
// pass over the matrix; the dimension register is written only while busy is low.
module adjacency_matrix_graph_store #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [6:0] src_vertex,
  input  logic [6:0] dst_vertex,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output logic       result_valid,
  output logic [6:0] neighbor,
  output logic       found,
  output logic       accepted,
  output logic [6:0] vertices_used,
  output logic       last
);
  import amgs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  amgs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .st    (st)
  );

  amgs_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .busy          (busy),
    .req_type      (req_type),
    .src_vertex    (src_vertex),
    .dst_vertex    (dst_vertex),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .neighbor      (neighbor),
    .found         (found),
    .accepted      (accepted),
    .vertices_used (vertices_used),
    .last          (last)
  );

endmodule
